// File: design/double_ended_queue_defines.svh
// assertion macros for the double-ended queue
// used by files that check their own logic; expects clock and reset in scope
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// condition holds at every edge out of reset
`define DEQ_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("double_ended_queue: invariant violated");

// same-cycle implication
`define DEQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("double_ended_queue: implication violated");

// next-cycle implication
`define DEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("double_ended_queue: sequence violated");

`endif

// File: design/deq_pkg.sv
// shared constants and types for the double-ended queue
// no dependencies
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEFAULT  = 16;
   localparam int DATA_W_DEFAULT = 32;
   localparam int REQ_W          = 3;
   localparam int STATUS_W       = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd2;

   // memory port controls from the pointer logic
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_op_type;

endpackage

`default_nettype wire

// File: design/deq_if.sv
// request and response channel interfaces for the double-ended queue
// depends on deq_pkg
`default_nettype none

interface deq_req_if #(
   parameter int DATA_W = deq_pkg::DATA_W_DEFAULT
);
   logic                        valid;
   logic                        ready;
   logic [deq_pkg::REQ_W-1:0]   req_type;
   logic [DATA_W-1:0]           data_in;

   modport source (output valid, output req_type, output data_in, input ready);
   modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface deq_rsp_if #(
   parameter int DATA_W = deq_pkg::DATA_W_DEFAULT,
   parameter int CNT_W  = $clog2(deq_pkg::DEPTH_DEFAULT + 1)
);
   logic                         valid;
   logic                         ready;
   logic [DATA_W-1:0]            data_out;
   logic [deq_pkg::STATUS_W-1:0] status;
   logic [CNT_W-1:0]             entry_total;
   logic                         is_empty;

   modport source (output valid, output data_out, output status, output entry_total,
                   output is_empty, input ready);
   modport sink   (input valid, input data_out, input status, input entry_total,
                   input is_empty, output ready);
endinterface

`default_nettype wire

// File: design/deq_mem.sv
// slot store: single-port synchronous memory with registered read data
// depends on deq_pkg
`default_nettype none

module deq_mem #(
   parameter int DEPTH  = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_W = deq_pkg::DATA_W_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire deq_pkg::mem_op_type mem_op,
   input  wire logic [ADDR_W-1:0]   addr,
   input  wire logic [DATA_W-1:0]   wr_data,
   output logic      [DATA_W-1:0]   rd_data
);

   logic [DATA_W-1:0] slot_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_op.wr_en) begin
         slot_mem[addr] <= wr_data;
      end
      if (mem_op.rd_en) begin
         rd_data_ff <= slot_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/deq_ctrl.sv
// pointer, count and direction logic plus the response register
// depends on deq_pkg, deq_if and double_ended_queue_defines.svh
`default_nettype none

`include "double_ended_queue_defines.svh"

module deq_ctrl #(
   parameter int DEPTH  = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_W = deq_pkg::DATA_W_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   deq_req_if.sink                    req_ch,
   deq_rsp_if.source                  rsp_ch,
   output deq_pkg::mem_op_type        mem_op,
   output logic      [ADDR_W-1:0]     mem_addr,
   output logic      [DATA_W-1:0]     mem_wr_data,
   input  wire logic [DATA_W-1:0]     mem_rd_data
);

   localparam logic [CNT_W:0]    DEPTH_SUM  = (CNT_W+1)'(DEPTH);
   localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(DEPTH - 1);

   function automatic logic [ADDR_W-1:0] wrap_slot(input logic [CNT_W:0] s);
      if (s >= DEPTH_SUM) begin
         return ADDR_W'(s - DEPTH_SUM);
      end
      return ADDR_W'(s);
   endfunction

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rev_ff, rev_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_pop_ff, rsp_pop_in;
   logic [deq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]             rsp_total_ff;
   logic                         rsp_empty_ff;

   logic              accept;
   logic              at_back;
   logic              use_tail;
   logic [CNT_W:0]    fill_sum;
   logic [ADDR_W-1:0] tail_put;
   logic [ADDR_W-1:0] tail_take;
   logic [ADDR_W-1:0] head_dec;
   logic [ADDR_W-1:0] head_inc;

   // a new transaction enters only when the response register frees up
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign fill_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
   assign tail_put  = wrap_slot(fill_sum);
   assign tail_take = wrap_slot(fill_sum - (CNT_W+1)'(1));
   assign head_dec  = (head_ff == '0) ? LAST_SLOT : head_ff - ADDR_W'(1);
   assign head_inc  = (head_ff == LAST_SLOT) ? '0 : head_ff + ADDR_W'(1);

   assign at_back  = (req_ch.req_type == deq_pkg::REQ_PUSH_BACK) ||
                     (req_ch.req_type == deq_pkg::REQ_POP_BACK);
   // reversal swaps which physical end is the logical back
   assign use_tail = at_back ^ rev_ff;

   assign mem_wr_data = req_ch.data_in;

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      rev_in        = rev_ff;
      mem_op        = '0;
      mem_addr      = head_ff;
      rsp_pop_in    = 1'b0;
      rsp_status_in = deq_pkg::STATUS_OK;
      case (req_ch.req_type)
         deq_pkg::REQ_PUSH_BACK, deq_pkg::REQ_PUSH_FRONT: begin
            if (count_ff >= DEPTH_CNT) begin
               rsp_status_in = deq_pkg::STATUS_PUSH_FULL;
            end else begin
               mem_op.wr_en = accept;
               count_in     = count_ff + CNT_W'(1);
               if (use_tail) begin
                  mem_addr = tail_put;
               end else begin
                  mem_addr = head_dec;
                  head_in  = head_dec;
               end
            end
         end
         deq_pkg::REQ_POP_BACK, deq_pkg::REQ_POP_FRONT: begin
            if (count_ff == '0) begin
               rsp_status_in = deq_pkg::STATUS_POP_EMPTY;
            end else begin
               mem_op.rd_en = accept;
               rsp_pop_in   = 1'b1;
               count_in     = count_ff - CNT_W'(1);
               if (use_tail) begin
                  mem_addr = tail_take;
               end else begin
                  mem_addr = head_ff;
                  head_in  = head_inc;
               end
            end
         end
         deq_pkg::REQ_REVERSE: begin
            rev_in = !rev_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
            rev_ff   <= rev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pop_ff    <= rsp_pop_in;
         rsp_status_ff <= rsp_status_in;
         rsp_total_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.data_out    = rsp_pop_ff ? mem_rd_data : '0;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_total = rsp_total_ff;
   assign rsp_ch.is_empty    = rsp_empty_ff;

   `DEQ_ASSERT(count_in_range, count_ff <= DEPTH_CNT)
   `DEQ_ASSERT(one_mem_access, !(mem_op.wr_en && mem_op.rd_en))
   `DEQ_ASSERT_NEXT(accept_gives_rsp, accept, rsp_valid_ff)
   `DEQ_ASSERT_NEXT(pop_drops_count, accept && mem_op.rd_en,
                    count_ff == $past(count_ff) - CNT_W'(1))
   `DEQ_ASSERT_IMPL(empty_matches_total, rsp_valid_ff,
                    rsp_empty_ff == (rsp_total_ff == '0))

endmodule

`default_nettype wire

// File: design/double_ended_queue.sv
// Bounded double-ended queue of DATA_W-bit words, DEPTH slots deep.
// Request channel req_ch carries req_type (push back, push front, pop back,
// pop front, reverse) and data_in; a transaction moves on valid and ready
// both high at a rising clock edge. Response channel rsp_ch returns exactly
// one transaction per request: data_out (popped word or zero), status (ok,
// pop on empty, push on full dropped), entry_total and is_empty.
// The response is valid on the cycle after the request is taken,
// since the popped word comes from the single-port slot memory, which has a
// registered read. Throughput: one request per cycle while the receiver takes responses;
// each request makes at most one access to that memory port and updates the pointers in one step.
// Reverse toggles a direction flag and touches no slot.
// If the receiver stalls, the response register holds and req_ch.ready falls
// until the waiting response is taken; it may be taken in the same cycle as
// the next request enters. Reset (synchronous, active high) empties the
// queue, clears the direction flag and drops any pending response; the slot
// memory is not cleared and needs no clearing pass.
// depends on deq_pkg, deq_if, deq_mem and deq_ctrl
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH  = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_W = deq_pkg::DATA_W_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   deq_req_if.sink   req_ch,
   deq_rsp_if.source rsp_ch
);

   localparam int ADDR_W = $clog2(DEPTH);

   deq_pkg::mem_op_type mem_op;
   logic [ADDR_W-1:0]   mem_addr;
   logic [DATA_W-1:0]   mem_wr_data;
   logic [DATA_W-1:0]   mem_rd_data;

   deq_ctrl #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_op      (mem_op),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   deq_mem #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W)
   ) u_mem (
      .clock   (clock),
      .mem_op  (mem_op),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// File: test/tb_double_ended_queue.sv
// self-checking testbench for the double-ended queue: directed table, then random requests
// a predictor or a fixed row checks every response; depends on deq_pkg, deq_if and the rtl
`default_nettype none

module tb_double_ended_queue;

   localparam int DEPTH       = deq_pkg::DEPTH_DEFAULT;
   localparam int DATA_W      = deq_pkg::DATA_W_DEFAULT;
   localparam int REQ_W       = deq_pkg::REQ_W;
   localparam int STATUS_W    = deq_pkg::STATUS_W;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int RANDOM_REQS = 1800;
   localparam int CYCLE_LIMIT = 200000;

   // request codes the block treats as no operation
   localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0]   data_out;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    entry_total;
      logic                is_empty;
   } deq_result_type;

   typedef struct packed {
      logic [REQ_W-1:0]  op;
      logic [DATA_W-1:0] word;
      int                reps;
      bit                fixed;
      deq_result_type    want;
   } stim_row_type;

   logic clock;
   logic reset;

   deq_req_if #(.DATA_W(DATA_W)) req_ch ();
   deq_rsp_if #(.DATA_W(DATA_W), .CNT_W(CNT_W)) rsp_ch ();

   double_ended_queue #(.DEPTH(DEPTH), .DATA_W(DATA_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow of the queue contents
   logic [DATA_W-1:0] shadow_slots [DEPTH];
   int                shadow_head;
   int                shadow_fill;
   bit                shadow_flipped;

   deq_result_type pending_results [$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             tx_idle_pct;
   int             rx_idle_pct;

   stim_row_type directed_rows [] = '{
      '{deq_pkg::REQ_POP_BACK,   32'h0000_0000, 1, 1'b1,
        '{'0, deq_pkg::STATUS_POP_EMPTY, 5'd0, 1'b1}},
      '{deq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1, 1'b1,
        '{'0, deq_pkg::STATUS_POP_EMPTY, 5'd0, 1'b1}},
      '{deq_pkg::REQ_REVERSE,    32'hFFFF_FFFF, 1, 1'b1,
        '{'0, deq_pkg::STATUS_OK, 5'd0, 1'b1}},
      '{REQ_UNUSED_LO,           32'h1234_5678, 1, 1'b1,
        '{'0, deq_pkg::STATUS_OK, 5'd0, 1'b1}},
      '{REQ_UNUSED_HI,           32'hFFFF_FFFF, 1, 1'b1,
        '{'0, deq_pkg::STATUS_OK, 5'd0, 1'b1}},
      '{deq_pkg::REQ_REVERSE,    32'h0000_0000, 1, 1'b1,
        '{'0, deq_pkg::STATUS_OK, 5'd0, 1'b1}},
      '{deq_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFF, 1, 1'b1,
        '{'0, deq_pkg::STATUS_OK, 5'd1, 1'b0}},
      '{deq_pkg::REQ_PUSH_FRONT, 32'h0000_0000, 1, 1'b1,
        '{'0, deq_pkg::STATUS_OK, 5'd2, 1'b0}},
      '{deq_pkg::REQ_PUSH_BACK,  32'h5A5A_A5A5, 1, 1'b0, '0},
      '{deq_pkg::REQ_REVERSE,    32'h0000_0000, 1, 1'b0, '0},
      '{deq_pkg::REQ_POP_BACK,   32'h0000_0000, 1, 1'b0, '0},
      '{deq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1, 1'b0, '0},
      // fill to the brim with random words
      '{deq_pkg::REQ_PUSH_FRONT, 32'h0000_0000, 15, 1'b0, '0},
      '{deq_pkg::REQ_PUSH_BACK,  32'hDEAD_BEEF, 1, 1'b1,
        '{'0, deq_pkg::STATUS_PUSH_FULL, 5'd16, 1'b0}},
      '{deq_pkg::REQ_PUSH_FRONT, 32'h8000_0001, 1, 1'b1,
        '{'0, deq_pkg::STATUS_PUSH_FULL, 5'd16, 1'b0}},
      '{deq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1, 1'b0, '0},
      '{deq_pkg::REQ_REVERSE,    32'h0000_0000, 1, 1'b0, '0},
      '{deq_pkg::REQ_POP_BACK,   32'h0000_0000, 1, 1'b0, '0},
      '{deq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1, 1'b0, '0}
   };

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic deq_result_type deque_apply(input logic [REQ_W-1:0] op,
                                                  input logic [DATA_W-1:0] word);
      deq_result_type res;
      bit             at_back;
      res = '0;
      case (op)
         deq_pkg::REQ_PUSH_BACK, deq_pkg::REQ_PUSH_FRONT: begin
            if (shadow_fill >= DEPTH) begin
               res.status = deq_pkg::STATUS_PUSH_FULL;
            end else begin
               at_back = (op == deq_pkg::REQ_PUSH_BACK);
               // the reversed flag swaps which physical end is the logical back
               if (at_back != shadow_flipped) begin
                  shadow_slots[(shadow_head + shadow_fill) % DEPTH] = word;
               end else begin
                  shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                  shadow_slots[shadow_head] = word;
               end
               shadow_fill++;
            end
         end
         deq_pkg::REQ_POP_BACK, deq_pkg::REQ_POP_FRONT: begin
            if (shadow_fill == 0) begin
               res.status = deq_pkg::STATUS_POP_EMPTY;
            end else begin
               at_back = (op == deq_pkg::REQ_POP_BACK);
               if (at_back != shadow_flipped) begin
                  res.data_out = shadow_slots[(shadow_head + shadow_fill - 1) % DEPTH];
               end else begin
                  res.data_out = shadow_slots[shadow_head];
                  shadow_head = (shadow_head + 1) % DEPTH;
               end
               shadow_fill--;
            end
         end
         deq_pkg::REQ_REVERSE: shadow_flipped = !shadow_flipped;
         default: ;
      endcase
      res.entry_total = shadow_fill[CNT_W-1:0];
      res.is_empty    = (shadow_fill == 0);
      return res;
   endfunction

   // offer one request, wait for the transaction, then record what should come back
   task automatic send_request(input logic [REQ_W-1:0] op, input logic [DATA_W-1:0] word,
                               input bit fixed, input deq_result_type want);
      deq_result_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= op;
      req_ch.data_in  <= word;
      do @(posedge clock); while (!req_ch.ready);
      predicted = deque_apply(op, word);
      pending_results.push_back(fixed ? want : predicted);
   endtask

   // response side: random back-pressure plus an occasional long hold-off
   initial begin : response_side
      int hold_left;
      int rx_cycles;
      hold_left = 0;
      rx_cycles = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycles++;
         if (rx_cycles % 1500 == 700) hold_left = 48;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      deq_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("response transaction with nothing expected");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.data_out !== want.data_out) begin
               $error("data_out expected %h got %h", want.data_out, rsp_ch.data_out);
               error_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.entry_total !== want.entry_total) begin
               $error("entry_total expected %0d got %0d", want.entry_total,
                      rsp_ch.entry_total);
               error_count++;
            end
            if (rsp_ch.is_empty !== want.is_empty) begin
               $error("is_empty expected %0b got %0b", want.is_empty, rsp_ch.is_empty);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [REQ_W-1:0]  op;
      logic [DATA_W-1:0] word;
      int                pick;
      int                push_share;
      clock           = 1'b0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = deq_pkg::REQ_PUSH_BACK;
      req_ch.data_in  = '0;
      shadow_head     = 0;
      shadow_fill     = 0;
      shadow_flipped  = 1'b0;
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
      tx_idle_pct     = 34;
      rx_idle_pct     = 63;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            word = (directed_rows[r].reps > 1) ? DATA_W'($urandom) : directed_rows[r].word;
            send_request(directed_rows[r].op, word, directed_rows[r].fixed,
                         directed_rows[r].want);
         end
      end

      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n == RANDOM_REQS / 3) begin
            tx_idle_pct = 63;
            rx_idle_pct = 34;
         end else if (n == 2 * RANDOM_REQS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         // sweep the fill level between full and empty in stretches
         case ((n / 60) % 3)
            0:       push_share = 68;
            1:       push_share = 22;
            default: push_share = 45;
         endcase
         pick = $urandom_range(99);
         if (pick < 2) begin
            op = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
         end else if (pick < 10) begin
            op = deq_pkg::REQ_REVERSE;
         end else if (pick < 10 + push_share) begin
            op = $urandom_range(1) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT;
         end else begin
            op = $urandom_range(1) ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT;
         end
         case ($urandom_range(7))
            0:       word = '0;
            1:       word = '1;
            default: word = DATA_W'($urandom);
         endcase
         send_request(op, word, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+design
design/deq_pkg.sv
design/deq_if.sv
design/deq_mem.sv
design/deq_ctrl.sv
design/double_ended_queue.sv
test/tb_double_ended_queue.sv
